@@ rtl/dsmu_pkg.sv @@
// ----------------------------------------------------------------------------
// dsmu_pkg
// Shared types and register map constants for the dual-side messaging unit.
// ----------------------------------------------------------------------------
package dsmu_pkg;

	// Flag registers are always four channels wide
	localparam int FLAG_W = 4;
	localparam int FC_W   = 3;
	localparam int DATA_W = 32;
	localparam int OFS_W  = 12;
	localparam int SIZE_W = 3;

	// Access kind
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Only full-word accesses are handled
	localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

	// Register map, per side
	localparam logic [OFS_W-1:0] OFS_VER     = 12'h000;
	localparam logic [OFS_W-1:0] OFS_PAR     = 12'h004;
	localparam logic [OFS_W-1:0] OFS_CR      = 12'h008;
	localparam logic [OFS_W-1:0] OFS_SR      = 12'h00C;
	localparam logic [OFS_W-1:0] OFS_FCR     = 12'h100;
	localparam logic [OFS_W-1:0] OFS_FSR     = 12'h104;
	localparam logic [OFS_W-1:0] OFS_GIER    = 12'h110;
	localparam logic [OFS_W-1:0] OFS_GCR     = 12'h114;
	localparam logic [OFS_W-1:0] OFS_GSR     = 12'h118;
	localparam logic [OFS_W-1:0] OFS_TCR     = 12'h120;
	localparam logic [OFS_W-1:0] OFS_TSR     = 12'h124;
	localparam logic [OFS_W-1:0] OFS_RCR     = 12'h128;
	localparam logic [OFS_W-1:0] OFS_RSR     = 12'h12C;
	localparam logic [OFS_W-1:0] OFS_TX_BASE = 12'h200;
	localparam logic [OFS_W-1:0] OFS_RX_BASE = 12'h280;

	// Status register bit positions
	localparam int SR_GEN_POS = 4;
	localparam int SR_TX_POS  = 5;
	localparam int SR_RX_POS  = 6;

	// One bus access
	typedef struct packed {
		logic              func;
		logic              side;
		logic [OFS_W-1:0]  offset;
		logic [SIZE_W-1:0] access_size;
		logic [DATA_W-1:0] write_data;
		logic              peek;
	} access_t;

	// One access result
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              handled;
		logic              irq_side_a;
		logic              irq_side_b;
	} result_t;

endpackage

@@ rtl/dsmu_core.sv @@
// ----------------------------------------------------------------------------
// dsmu_core
// Register file of both sides plus access decode. Result is combinational
// from the presented access; state updates on commit.
// ----------------------------------------------------------------------------
module dsmu_core #(
	parameter int CHANNEL_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  dsmu_pkg::access_t acc,
	output dsmu_pkg::result_t res
);
	import dsmu_pkg::*;

	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam logic [OFS_W-1:0] TX_END = OFS_W'(OFS_TX_BASE + 4 * CHANNEL_COUNT);
	localparam logic [OFS_W-1:0] RX_END = OFS_W'(OFS_RX_BASE + 4 * CHANNEL_COUNT);
	localparam logic [FLAG_W-1:0] CH_USED = FLAG_W'((1 << CHANNEL_COUNT) - 1);

	// Per-side state
	logic [FLAG_W-1:0] rx_full_q [2];
	logic [FLAG_W-1:0] gstat_q   [2];
	logic [FLAG_W-1:0] greq_q    [2];
	logic [FLAG_W-1:0] tcr_q     [2];
	logic [FLAG_W-1:0] rcr_q     [2];
	logic [FLAG_W-1:0] gier_q    [2];
	logic [FC_W-1:0]   fc_q      [2];
	logic [DATA_W-1:0] rx_word_q [2][CHANNEL_COUNT];

	logic [FLAG_W-1:0] rx_full_d [2];
	logic [FLAG_W-1:0] gstat_d   [2];
	logic [FLAG_W-1:0] greq_d    [2];
	logic [FLAG_W-1:0] tcr_d     [2];
	logic [FLAG_W-1:0] rcr_d     [2];
	logic [FLAG_W-1:0] gier_d    [2];
	logic [FC_W-1:0]   fc_d      [2];

	logic              own;
	logic              peer;
	logic [OFS_W-1:0]  tx_rel;
	logic [OFS_W-1:0]  rx_rel;
	logic [CH_W-1:0]   tx_ch;
	logic [CH_W-1:0]   rx_ch;
	logic              tx_hit;
	logic              rx_hit;
	logic              word_we;
	logic              ok;
	logic [DATA_W-1:0] rd;
	logic [FLAG_W-1:0] wr_flags;
	logic [FLAG_W-1:0] tx_empty_own;
	logic              irq_a;
	logic              irq_b;

	// Address windows and channel select
	assign own    = acc.side;
	assign peer   = ~acc.side;
	assign tx_rel = acc.offset - OFS_TX_BASE;
	assign rx_rel = acc.offset - OFS_RX_BASE;
	assign tx_ch  = tx_rel[CH_W+1:2];
	assign rx_ch  = rx_rel[CH_W+1:2];
	assign tx_hit = (acc.offset >= OFS_TX_BASE) && (acc.offset < TX_END);
	assign rx_hit = (acc.offset >= OFS_RX_BASE) && (acc.offset < RX_END);
	assign wr_flags     = acc.write_data[FLAG_W-1:0];
	assign tx_empty_own = ~rx_full_q[peer];

	// Access decode and next state
	always_comb begin
		rx_full_d = rx_full_q;
		gstat_d   = gstat_q;
		greq_d    = greq_q;
		tcr_d     = tcr_q;
		rcr_d     = rcr_q;
		gier_d    = gier_q;
		fc_d      = fc_q;
		word_we   = 1'b0;
		ok        = 1'b0;
		rd        = '0;
		if (acc.access_size == SIZE_WORD) begin
			if (acc.func == FUNC_WRITE) begin
				if (tx_hit) begin
					word_we = 1'b1;
					rx_full_d[peer] = rx_full_q[peer] | (FLAG_W'(1) << tx_ch);
					ok = 1'b1;
				end else if (rx_hit) begin
					ok = 1'b1;
				end else begin
					unique case (acc.offset)
						OFS_GCR: begin
							greq_d[own]  = wr_flags;
							gstat_d[peer] = gstat_q[peer] | wr_flags;
							ok = 1'b1;
						end
						OFS_GSR: begin
							gstat_d[own] = gstat_q[own] & ~wr_flags;
							ok = 1'b1;
						end
						OFS_CR: begin
							if (acc.write_data[0]) begin
								rx_full_d[0] = '0;
								rx_full_d[1] = '0;
								gstat_d[0]   = '0;
								gstat_d[1]   = '0;
								ok = 1'b1;
							end
						end
						OFS_TSR, OFS_RSR, OFS_FSR, OFS_SR, OFS_VER, OFS_PAR: begin
							ok = 1'b1;
						end
						OFS_TCR: begin
							tcr_d[own] = wr_flags;
							ok = 1'b1;
						end
						OFS_RCR: begin
							rcr_d[own] = wr_flags;
							ok = 1'b1;
						end
						OFS_GIER: begin
							gier_d[own] = wr_flags;
							ok = 1'b1;
						end
						OFS_FCR: begin
							fc_d[own] = acc.write_data[FC_W-1:0];
							ok = 1'b1;
						end
						default: ok = 1'b0;
					endcase
				end
			end else begin
				if (rx_hit) begin
					rd = rx_word_q[own][rx_ch];
					if (!acc.peek) begin
						rx_full_d[own] = rx_full_q[own] & ~(FLAG_W'(1) << rx_ch);
					end
					ok = 1'b1;
				end else begin
					ok = 1'b1;
					unique case (acc.offset)
						OFS_TSR:  rd = DATA_W'(tx_empty_own);
						OFS_RSR:  rd = DATA_W'(rx_full_q[own]);
						OFS_GSR:  rd = DATA_W'(gstat_q[own]);
						OFS_GCR:  rd = DATA_W'(gstat_q[peer] & greq_q[own]);
						OFS_FSR:  rd = DATA_W'(fc_q[peer]);
						OFS_FCR:  rd = DATA_W'(fc_q[own]);
						OFS_GIER: rd = DATA_W'(gier_q[own]);
						OFS_TCR:  rd = DATA_W'(tcr_q[own]);
						OFS_RCR:  rd = DATA_W'(rcr_q[own]);
						OFS_SR: begin
							rd[SR_TX_POS]  = |(tx_empty_own & tcr_q[own]);
							rd[SR_RX_POS]  = |(rx_full_q[own] & rcr_q[own]);
							rd[SR_GEN_POS] = |(gstat_q[peer] & greq_q[own]);
						end
						default: ok = 1'b0;
					endcase
				end
			end
		end
	end

	// Interrupt levels from the post-access state
	assign irq_a = |((~rx_full_d[1] & tcr_d[0]) | (rx_full_d[0] & rcr_d[0]) |
	                 (gstat_d[0] & gier_d[0]));
	assign irq_b = |((~rx_full_d[0] & tcr_d[1]) | (rx_full_d[1] & rcr_d[1]) |
	                 (gstat_d[1] & gier_d[1]));

	assign res.read_data  = rd;
	assign res.handled    = ok;
	assign res.irq_side_a = irq_a;
	assign res.irq_side_b = irq_b;

	// Flag and enable registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				rx_full_q[i] <= '0;
				gstat_q[i]   <= '0;
				greq_q[i]    <= '0;
				tcr_q[i]     <= '0;
				rcr_q[i]     <= '0;
				gier_q[i]    <= '0;
				fc_q[i]      <= '0;
			end
		end else if (commit) begin
			rx_full_q <= rx_full_d;
			gstat_q   <= gstat_d;
			greq_q    <= greq_d;
			tcr_q     <= tcr_d;
			rcr_q     <= rcr_d;
			gier_q    <= gier_d;
			fc_q      <= fc_d;
		end
	end

	// Message words; reads of never-written words return zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < CHANNEL_COUNT; j++) begin
					rx_word_q[i][j] <= '0;
				end
			end
		end else if (commit && word_we) begin
			rx_word_q[peer][tx_ch] <= acc.write_data;
		end
	end

	// Unused channels never report full
	a_unused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((rx_full_q[0] & ~CH_USED) == '0) && ((rx_full_q[1] & ~CH_USED) == '0))
		else $error("full flag set on unused channel");

	// Writes never return data
	a_write_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (acc.func == FUNC_WRITE) |-> (res.read_data == '0))
		else $error("write returned read data");

	// Control reset clears all flags of both sides
	a_ctrl_clear: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (acc.func == FUNC_WRITE) && (acc.access_size == SIZE_WORD) &&
		(acc.offset == OFS_CR) && acc.write_data[0]
		|=> (rx_full_q[0] == '0) && (rx_full_q[1] == '0) &&
		    (gstat_q[0] == '0) && (gstat_q[1] == '0))
		else $error("control reset left flags set");

endmodule

@@ rtl/dual_side_messaging_unit_top.sv @@
// ----------------------------------------------------------------------------
// dual_side_messaging_unit_top
// Two-sided messaging unit: bus accesses in, one result per access out.
//
//   Channel  Dir  Content
//   s_*      in   one register access from side A or B
//   m_*      out  read data, handled flag and both interrupt levels
//
// One access per cycle sustained while m_tready stays high.
// The access sits in an input register, is decoded against the
// flag registers and its result is captured in the output register.
// Reset clears all flags, enables and message words; no warm-up pass.
// A stalled output holds its result while the input register still takes
// one more access; s_tready drops only when both are occupied.
// ----------------------------------------------------------------------------
module dual_side_messaging_unit_top #(
	parameter int CHANNEL_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: offset[11:0], access_size[14:12], write_data[46:15], zero[47]
	input  logic [47:0] s_tdata,
	// tuser: func[0], side[1], peek[2]
	input  logic [2:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: read_data[31:0], handled[32], irq_side_a[33], irq_side_b[34], zero[39:35]
	output logic [39:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready
);
	import dsmu_pkg::*;

	logic    valid_s1;
	access_t acc_s1;
	logic    advance;
	logic    out_valid_q;
	result_t res;
	result_t out_q;

	// Input stage moves when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			acc_s1.func        <= s_tuser[0];
			acc_s1.side        <= s_tuser[1];
			acc_s1.peek        <= s_tuser[2];
			acc_s1.offset      <= s_tdata[11:0];
			acc_s1.access_size <= s_tdata[14:12];
			acc_s1.write_data  <= s_tdata[46:15];
		end
	end

	dsmu_core #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.acc    (acc_s1),
		.res    (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.irq_side_b, out_q.irq_side_a, out_q.handled,
	                   out_q.read_data};

	// A committed access always shows up on the output
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("committed access produced no result");

	// A held input stage must block new accesses
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_tready)
		else $error("input accepted over a held access");

	// An accepted access occupies the input stage next cycle
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted access lost");

endmodule

@@ dv/dual_side_messaging_unit_top_tb.sv @@
// ----------------------------------------------------------------------------
// dual_side_messaging_unit_top_tb
// Self-checking bench for the dual-side messaging unit. Register accesses
// from both sides are streamed in with bursty timing while the result side
// stalls on its own schedule. A behavioral copy of both sides' flag and
// message state predicts each result, and a scoreboard matches every result
// transaction against it in order. A directed pass exercises the register
// map and its corner cases. Random traffic follows, mostly message exchange
// and flag handling. A long output stall fills the pipeline, and a
// noise-only pass covers wrong sizes and unknown offsets.
// ----------------------------------------------------------------------------
module dual_side_messaging_unit_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsmu_pkg::*;

	localparam int N_CH = 4;
	localparam logic [OFS_W-1:0] WIN_BYTES = OFS_W'(4 * N_CH);
	localparam logic SIDE_A = 1'b0;
	localparam logic SIDE_B = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;

	dual_side_messaging_unit_top #(
		.CHANNEL_COUNT(N_CH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	always #1 clk = ~clk;

	// Mirror of both sides' state, index 0 is side A
	logic [FLAG_W-1:0] rx_full [2];
	logic [DATA_W-1:0] rx_word [8];
	logic [FLAG_W-1:0] gen_status [2];
	logic [FLAG_W-1:0] gen_req [2];
	logic [FLAG_W-1:0] tx_ie [2];
	logic [FLAG_W-1:0] rx_ie [2];
	logic [FLAG_W-1:0] gen_ie [2];
	logic [FC_W-1:0]   flag_ctl [2];

	result_t pending_results [$];
	int unsigned err_count = 0;

	// Sender burst state and receiver stall control
	int unsigned burst_left = 0;
	bit          steady_send = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	int unsigned rx_mode = 0;

	logic [OFS_W-1:0] reg_map [13] = '{OFS_VER, OFS_PAR, OFS_CR, OFS_SR, OFS_FCR, OFS_FSR,
		OFS_GIER, OFS_GCR, OFS_GSR, OFS_TCR, OFS_TSR, OFS_RCR, OFS_RSR};

	function automatic logic [FLAG_W-1:0] tx_empty(logic s);
		return ~rx_full[s ^ 1'b1];
	endfunction

	function automatic logic irq_level(logic s);
		return |((tx_empty(s) & tx_ie[s]) | (rx_full[s] & rx_ie[s]) |
			(gen_status[s] & gen_ie[s]));
	endfunction

	// Apply one access to the mirrored state and return its outcome
	function automatic result_t access_outcome(access_t a);
		result_t           r;
		logic              s;
		logic              p;
		logic [1:0]        ch;
		logic [OFS_W-1:0]  rel_tx;
		logic [OFS_W-1:0]  rel_rx;
		logic              ok;
		logic [DATA_W-1:0] rd;
		s = a.side;
		p = ~a.side;
		ok = 1'b0;
		rd = '0;
		rel_tx = a.offset - OFS_TX_BASE;
		rel_rx = a.offset - OFS_RX_BASE;
		if (a.access_size == SIZE_WORD && a.func == FUNC_WRITE) begin
			ok = 1'b1;
			if (a.offset >= OFS_TX_BASE && rel_tx < WIN_BYTES) begin
				ch = rel_tx[3:2];
				rx_word[{p, ch}] = a.write_data;
				rx_full[p][ch] = 1'b1;
			end else if (a.offset >= OFS_RX_BASE && rel_rx < WIN_BYTES) begin
				// receive words are read-only, write is absorbed
			end else begin
				case (a.offset)
					OFS_GCR: begin
						gen_req[s] = a.write_data[FLAG_W-1:0];
						gen_status[p] = gen_status[p] | a.write_data[FLAG_W-1:0];
					end
					OFS_GSR: gen_status[s] = gen_status[s] & ~a.write_data[FLAG_W-1:0];
					OFS_CR: begin
						if (a.write_data[0]) begin
							rx_full[0] = '0;
							rx_full[1] = '0;
							gen_status[0] = '0;
							gen_status[1] = '0;
						end else begin
							ok = 1'b0;
						end
					end
					OFS_TSR, OFS_RSR, OFS_FSR, OFS_SR, OFS_VER, OFS_PAR: ;
					OFS_TCR:  tx_ie[s] = a.write_data[FLAG_W-1:0];
					OFS_RCR:  rx_ie[s] = a.write_data[FLAG_W-1:0];
					OFS_GIER: gen_ie[s] = a.write_data[FLAG_W-1:0];
					OFS_FCR:  flag_ctl[s] = a.write_data[FC_W-1:0];
					default:  ok = 1'b0;
				endcase
			end
		end else if (a.access_size == SIZE_WORD) begin
			ok = 1'b1;
			if (a.offset >= OFS_RX_BASE && rel_rx < WIN_BYTES) begin
				ch = rel_rx[3:2];
				rd = rx_word[{s, ch}];
				if (!a.peek)
					rx_full[s][ch] = 1'b0;
			end else begin
				case (a.offset)
					OFS_TSR:  rd = DATA_W'(tx_empty(s));
					OFS_RSR:  rd = DATA_W'(rx_full[s]);
					OFS_GSR:  rd = DATA_W'(gen_status[s]);
					OFS_GCR:  rd = DATA_W'(gen_status[p] & gen_req[s]);
					OFS_FSR:  rd = DATA_W'(flag_ctl[p]);
					OFS_FCR:  rd = DATA_W'(flag_ctl[s]);
					OFS_GIER: rd = DATA_W'(gen_ie[s]);
					OFS_TCR:  rd = DATA_W'(tx_ie[s]);
					OFS_RCR:  rd = DATA_W'(rx_ie[s]);
					OFS_SR: begin
						rd[SR_TX_POS]  = |(tx_empty(s) & tx_ie[s]);
						rd[SR_RX_POS]  = |(rx_full[s] & rx_ie[s]);
						rd[SR_GEN_POS] = |(gen_status[p] & gen_req[s]);
					end
					default:  ok = 1'b0;
				endcase
			end
		end
		r.read_data  = (ok && a.func == FUNC_READ) ? rd : '0;
		r.handled    = ok;
		r.irq_side_a = irq_level(SIDE_A);
		r.irq_side_b = irq_level(SIDE_B);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] exp);
		$display("%0t ns: %s got 0x%08h expected 0x%08h", $time, what, got, exp);
		err_count++;
	endtask

	// Track accepted transactions on both sides and score results in order
	always @(posedge clk) begin : track
		access_t a;
		result_t exp_r;
		if (arst_n && s_tvalid && s_tready) begin
			a.offset      = s_tdata[11:0];
			a.access_size = s_tdata[14:12];
			a.write_data  = s_tdata[46:15];
			a.func        = s_tuser[0];
			a.side        = s_tuser[1];
			a.peek        = s_tuser[2];
			pending_results.push_back(access_outcome(a));
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending, read_data", m_tdata[31:0], '0);
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[31:0] !== exp_r.read_data)
					report_mismatch("read_data", m_tdata[31:0], exp_r.read_data);
				if (m_tdata[32] !== exp_r.handled)
					report_mismatch("handled", DATA_W'(m_tdata[32]),
						DATA_W'(exp_r.handled));
				if (m_tdata[33] !== exp_r.irq_side_a)
					report_mismatch("irq_side_a", DATA_W'(m_tdata[33]),
						DATA_W'(exp_r.irq_side_a));
				if (m_tdata[34] !== exp_r.irq_side_b)
					report_mismatch("irq_side_b", DATA_W'(m_tdata[34]),
						DATA_W'(exp_r.irq_side_b));
			end
		end
	end

	// Result-side stall pattern, with an on-demand long hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 1'b0;
		end
		if (mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 150);
		end
		mode_left--;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Offer one access and wait for its handshake; gaps fall between bursts
	task automatic send_access(input access_t a);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = steady_send ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= {1'b0, a.write_data, a.access_size, a.offset};
		s_tuser  <= {a.peek, a.side, a.func};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic access_t make_access(logic func, logic side, logic [OFS_W-1:0] offset,
		logic [SIZE_W-1:0] size, logic [DATA_W-1:0] data, logic peek);
		access_t a;
		a.func        = func;
		a.side        = side;
		a.offset      = offset;
		a.access_size = size;
		a.write_data  = data;
		a.peek        = peek;
		return a;
	endfunction

	// Mostly well-formed traffic; noise_pct percent fully random
	function automatic access_t random_access(int unsigned noise_pct);
		access_t     a;
		int unsigned pick;
		logic [3:0]  win;
		a.func        = 1'($urandom_range(0, 1));
		a.side        = 1'($urandom_range(0, 1));
		a.offset      = OFS_W'($urandom_range(0, 4095));
		a.access_size = SIZE_W'($urandom_range(0, 7));
		a.write_data  = $urandom;
		a.peek        = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < noise_pct)
			return a;
		a.access_size = SIZE_WORD;
		win = {2'($urandom_range(0, N_CH - 1)), 2'b00};
		if ($urandom_range(0, 7) == 0)
			win[1:0] = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 19);
		if (pick < 6) begin
			a.func = FUNC_WRITE;
			a.offset = OFS_TX_BASE + OFS_W'(win);
		end else if (pick < 12) begin
			a.func = ($urandom_range(0, 9) == 0) ? FUNC_WRITE : FUNC_READ;
			a.offset = OFS_RX_BASE + OFS_W'(win);
			a.peek = ($urandom_range(0, 4) == 0);
		end else if (pick < 14) begin
			a.offset = ($urandom_range(0, 1) != 0) ? OFS_GCR : OFS_GSR;
		end else if (pick < 18) begin
			a.offset = reg_map[$urandom_range(0, 12)];
			if (a.offset == OFS_CR && $urandom_range(0, 3) != 0)
				a.func = FUNC_READ;
		end else if (pick == 18) begin
			a.func = FUNC_WRITE;
			a.offset = OFS_CR;
			a.write_data[0] = ($urandom_range(0, 3) == 0);
		end
		return a;
	endfunction

	// Register map walk with the corner cases
	task automatic test_directed();
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_VER, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_VER, SIZE_WORD, '1, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_B, OFS_PAR, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_B, OFS_TCR, SIZE_WORD, 32'hFFFF_FFFF, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_RCR, SIZE_WORD, 32'h0000_000F, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_TX_BASE, SIZE_WORD, '1, 1'b0));
		// unaligned offset inside channel 3 window
		send_access(make_access(FUNC_WRITE, SIDE_B, OFS_TX_BASE + 12'hF, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_RSR, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_B, OFS_TSR, SIZE_WORD, '0, 1'b0));
		// peek leaves the full flag, plain read clears it
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_RX_BASE + 12'hC, SIZE_WORD, '0, 1'b1));
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_RX_BASE + 12'hE, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_B, OFS_RX_BASE, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_B, OFS_GIER, SIZE_WORD, 32'h0000_000F, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_GCR, SIZE_WORD, 32'hFFFF_FFFA, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_B, OFS_GSR, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_GCR, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_SR, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_B, OFS_GSR, SIZE_WORD, 32'h0000_0002, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_FCR, SIZE_WORD, '1, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_B, OFS_FSR, SIZE_WORD, '0, 1'b0));
		// wrong sizes change nothing
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_TX_BASE + 12'h4, 3'd1, '1, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_B, OFS_RSR, 3'd7, '0, 1'b0));
		// unknown offsets, including just past the receive window
		send_access(make_access(FUNC_READ,  SIDE_B, 12'hFFF, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_RX_BASE + WIN_BYTES, SIZE_WORD, '0, 1'b0));
		// control write without bit 0 is refused, control reads too
		send_access(make_access(FUNC_WRITE, SIDE_B, OFS_CR, SIZE_WORD, 32'hFFFF_FFFE, 1'b0));
		send_access(make_access(FUNC_READ,  SIDE_A, OFS_CR, SIZE_WORD, '0, 1'b0));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_RX_BASE + 12'h4, SIZE_WORD, '1, 1'b1));
		send_access(make_access(FUNC_WRITE, SIDE_B, OFS_TX_BASE + 12'h4, SIZE_WORD, '1, 1'b1));
		send_access(make_access(FUNC_WRITE, SIDE_A, OFS_CR, SIZE_WORD, 32'h0000_0001, 1'b0));
	endtask

	task automatic test_random_traffic(input int unsigned count);
		repeat (count) send_access(random_access(10));
	endtask

	// Long output stall while the sender keeps offering
	task automatic test_backpressure(input int unsigned count);
		steady_send = 1'b1;
		hold_req = 1'b1;
		repeat (count) send_access(random_access(10));
		steady_send = 1'b0;
	endtask

	task automatic test_noise(input int unsigned count);
		repeat (count) send_access(random_access(100));
	endtask

	initial begin
		for (int i = 0; i < 2; i++) begin
			rx_full[i] = '0;
			gen_status[i] = '0;
			gen_req[i] = '0;
			tx_ie[i] = '0;
			rx_ie[i] = '0;
			gen_ie[i] = '0;
			flag_ctl[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			rx_word[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(600);
		test_backpressure(60);
		test_random_traffic(400);
		test_noise(140);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
